FILE: src/sasd_pkg.sv
// ----------------------------------------------------------------------------
// sasd_pkg
// Shared types and constants for the two-stacks-in-one-store block.
// ----------------------------------------------------------------------------
`default_nettype none

package sasd_pkg;

    localparam int STORE_DEPTH   = 32;
    localparam int ELEMENT_WIDTH = 32;

    // Address and count widths follow the store depth.
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);

    // Fixed field widths of the stream payloads.
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 6;
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 3;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ
    } state_t;

endpackage : sasd_pkg

`default_nettype wire

FILE: src/shared_array_double_stack.sv
// ----------------------------------------------------------------------------
// shared_array_double_stack
// Two LIFO stacks in one synchronous store: stack 0 grows up from entry 0,
// stack 1 grows down from the last entry.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  tdata (low bit up)                    tuser (low bit up)
//  s_       in         push_value[31:0]                      mode[1:0], stack_sel[2]
//  m_       out        popped_value[31:0], total_count[37:32] status[1:0], all_empty[2]
//
//  A push, a clear, a refused operation or an unused mode has its result loaded
//  into the output register at the input transfer.
//  A successful pop first reads the store into a read register; the result is
//  loaded into the output register when the read data returns.
//  A new input transfer is taken while the output register is empty or is being
//  emptied in the same cycle, and not while a pop read is outstanding.
//  Reset clears both counts and the control state; the store needs no clearing.
//
`default_nettype none

module shared_array_double_stack (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [sasd_pkg::S_DATA_W-1:0] s_tdata,  // push_value[31:0]
    input  wire logic [sasd_pkg::S_USER_W-1:0] s_tuser,  // mode[1:0], stack_sel[2]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sasd_pkg::M_DATA_W-1:0]      m_tdata,  // popped_value[31:0],
                                                         // total_count[37:32], zero fill
    output logic [sasd_pkg::M_USER_W-1:0]      m_tuser   // status[1:0], all_empty[2]
);

    localparam int EW = sasd_pkg::ELEMENT_WIDTH;
    localparam int AW = sasd_pkg::ADDR_W;
    localparam int CW = sasd_pkg::CNT_W;

    logic [EW-1:0] mem [sasd_pkg::STORE_DEPTH];

    sasd_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     bot_cnt_reg, bot_cnt_next;
    logic [CW-1:0]     top_cnt_reg, top_cnt_next;

    logic                       out_valid_reg, out_valid_next;
    sasd_pkg::status_t          out_status_reg, out_status_next;
    logic [sasd_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    logic [sasd_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic                       out_empty_reg, out_empty_next;

    logic [EW-1:0] rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic                  accept;
    sasd_pkg::mode_t       in_mode;
    logic                  in_sel;
    logic [CW-1:0]         total;
    logic                  store_full;

    assign in_mode = sasd_pkg::mode_t'(s_tuser[1:0]);
    assign in_sel  = s_tuser[2];

    assign s_tready = (state_reg == sasd_pkg::ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign total       = bot_cnt_reg + top_cnt_reg;
    assign store_full  = (total == CW'(sasd_pkg::STORE_DEPTH));

    // The element keeps the low bits of the sign-extended input value.
    assign wr_data = EW'(signed'(s_tdata[sasd_pkg::VALUE_W-1:0]));

    always_comb begin
        state_next      = state_reg;
        bot_cnt_next    = bot_cnt_reg;
        top_cnt_next    = top_cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;
        wr_en           = 1'b0;
        wr_addr         = in_sel ? AW'(sasd_pkg::STORE_DEPTH - 1) - AW'(top_cnt_reg)
                                 : AW'(bot_cnt_reg);
        rd_en           = 1'b0;
        rd_addr         = in_sel ? AW'(sasd_pkg::STORE_DEPTH) - AW'(top_cnt_reg)
                                 : AW'(bot_cnt_reg - CW'(1));

        unique case (state_reg)
            sasd_pkg::ST_IDLE: begin
                if (accept) begin
                    out_status_next = sasd_pkg::STAT_DONE;
                    out_value_next  = '0;
                    out_valid_next  = 1'b1;
                    unique case (in_mode)
                        sasd_pkg::MODE_PUSH: begin
                            if (store_full) begin
                                out_status_next = sasd_pkg::STAT_FULL;
                            end else begin
                                wr_en = 1'b1;
                                if (in_sel) begin
                                    top_cnt_next = top_cnt_reg + CW'(1);
                                end else begin
                                    bot_cnt_next = bot_cnt_reg + CW'(1);
                                end
                            end
                        end
                        sasd_pkg::MODE_POP: begin
                            if ((in_sel ? top_cnt_reg : bot_cnt_reg) == '0) begin
                                out_status_next = sasd_pkg::STAT_EMPTY;
                            end else begin
                                // The result waits for the store read.
                                rd_en          = 1'b1;
                                out_valid_next = 1'b0;
                                state_next     = sasd_pkg::ST_READ;
                                if (in_sel) begin
                                    top_cnt_next = top_cnt_reg - CW'(1);
                                end else begin
                                    bot_cnt_next = bot_cnt_reg - CW'(1);
                                end
                            end
                        end
                        sasd_pkg::MODE_CLEAR: begin
                            bot_cnt_next = '0;
                            top_cnt_next = '0;
                        end
                        default: begin
                        end
                    endcase
                    out_count_next = sasd_pkg::COUNT_W'(bot_cnt_next + top_cnt_next);
                    out_empty_next = ((bot_cnt_next + top_cnt_next) == '0);
                end
            end
            sasd_pkg::ST_READ: begin
                // The output register is known to be empty here.
                out_valid_next  = 1'b1;
                out_status_next = sasd_pkg::STAT_DONE;
                out_value_next  = sasd_pkg::VALUE_W'(signed'(rd_data_reg));
                state_next      = sasd_pkg::ST_IDLE;
            end
            default: begin
                state_next = sasd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sasd_pkg::ST_IDLE;
            bot_cnt_reg   <= '0;
            top_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bot_cnt_reg   <= bot_cnt_next;
            top_cnt_reg   <= top_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(sasd_pkg::M_DATA_W - sasd_pkg::COUNT_W - sasd_pkg::VALUE_W)'(0),
                       out_count_reg, out_value_reg};
    assign m_tuser  = {out_empty_reg, out_status_reg};

endmodule : shared_array_double_stack

`default_nettype wire

FILE: test/shared_array_double_stack_tb.sv
// ----------------------------------------------------------------------------
// shared_array_double_stack_tb
// Self-checking bench for the shared-store double stack. A clocked driver
// offers push, pop, clear and unused-mode transfers from a queue. A clocked
// monitor keeps its own copy of both stacks and predicts every result, then
// checks the returned transfers in order. Both sides idle at random, and once
// the receiver holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module shared_array_double_stack_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_CYCLES  = 80;

    typedef struct {
        logic [1:0]  mode;
        logic        sel;
        logic [31:0] value;
    } stack_op_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] popped;
        logic [5:0]  total;
        logic        all_empty;
    } stack_result_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [sasd_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [sasd_pkg::S_USER_W-1:0] s_tuser  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [sasd_pkg::M_DATA_W-1:0] m_tdata;
    logic [sasd_pkg::M_USER_W-1:0] m_tuser;

    stack_op_t     pending_ops[$];
    stack_result_t awaited_results[$];

    // Private image of the block: the shared store and the two counts.
    logic [sasd_pkg::ELEMENT_WIDTH-1:0] store_image [sasd_pkg::STORE_DEPTH];
    int  lower_count = 0;
    int  upper_count = 0;

    logic in_taken    = 1'b0;
    int   cycle_count = 0;
    int   taken_count = 0;
    int   mismatches  = 0;
    int   hold_left   = 0;
    logic hold_done   = 1'b0;
    logic quiet_window;

    shared_array_double_stack dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // push_value[31:0]
        .s_tuser  (s_tuser),   // mode[1:0], stack_sel[2]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // popped_value[31:0], total_count[37:32], zero fill
        .m_tuser  (m_tuser)    // status[1:0], all_empty[2]
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Neither side idles inside this window.
    assign quiet_window = (cycle_count >= 600) && (cycle_count < 1000);

    function automatic stack_result_t predict_stack_result(stack_op_t op);
        stack_result_t r;
        int idx;
        r = '0;
        r.status = sasd_pkg::STAT_DONE;
        case (op.mode)
            sasd_pkg::MODE_PUSH: begin
                if (lower_count + upper_count >= sasd_pkg::STORE_DEPTH) begin
                    r.status = sasd_pkg::STAT_FULL;
                end else if (op.sel == 1'b0) begin
                    store_image[lower_count] = op.value[sasd_pkg::ELEMENT_WIDTH-1:0];
                    lower_count++;
                end else begin
                    store_image[sasd_pkg::STORE_DEPTH-1-upper_count] =
                        op.value[sasd_pkg::ELEMENT_WIDTH-1:0];
                    upper_count++;
                end
            end
            sasd_pkg::MODE_POP: begin
                if ((op.sel == 1'b0 && lower_count == 0) ||
                    (op.sel == 1'b1 && upper_count == 0)) begin
                    r.status = sasd_pkg::STAT_EMPTY;
                end else begin
                    if (op.sel == 1'b0) begin
                        lower_count--;
                        idx = lower_count;
                    end else begin
                        upper_count--;
                        idx = sasd_pkg::STORE_DEPTH - 1 - upper_count;
                    end
                    r.popped = 32'($signed(store_image[idx]));
                end
            end
            sasd_pkg::MODE_CLEAR: begin
                lower_count = 0;
                upper_count = 0;
            end
            default: ;
        endcase
        r.total     = 6'(lower_count + upper_count);
        r.all_empty = (lower_count + upper_count == 0);
        return r;
    endfunction

    task automatic add_op(logic [1:0] mode, logic sel, logic [31:0] value);
        stack_op_t op;
        op.mode  = mode;
        op.sel   = sel;
        op.value = value;
        pending_ops.push_back(op);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Input and output transfers are both seen here, at the rising edge.
    always @(posedge aclk) begin : transfer_monitor
        stack_op_t     op;
        stack_result_t got;
        stack_result_t want;
        cycle_count <= cycle_count + 1;
        in_taken    <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            op.mode  = s_tuser[1:0];
            op.sel   = s_tuser[2];
            op.value = s_tdata;
            awaited_results.push_back(predict_stack_result(op));
            taken_count <= taken_count + 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.status    = m_tuser[1:0];
            got.all_empty = m_tuser[2];
            got.popped    = m_tdata[31:0];
            got.total     = m_tdata[37:32];
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d popped %h total %0d empty %0b",
                             got.status, got.popped, got.total, got.all_empty);
            end else begin
                want = awaited_results.pop_front();
                if (got.status != want.status || got.popped != want.popped ||
                    got.total != want.total || got.all_empty != want.all_empty) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at cycle %0d: status %0d/%0d popped %h/%h ",
                                  "total %0d/%0d empty %0b/%0b (expected/actual)"},
                                 cycle_count, want.status, got.status, want.popped,
                                 got.popped, want.total, got.total, want.all_empty,
                                 got.all_empty);
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin : stim_driver
        stack_op_t op;
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (pending_ops.size() > 0 && (quiet_window || $urandom_range(99) >= 24)) begin
                op = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= op.value;
                s_tuser  <= {op.sel, op.mode};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // The long hold-off lets the sender keep offering until the block stalls.
    always @(negedge aclk) begin : result_sink
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!hold_done && taken_count >= 300) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= quiet_window || ($urandom_range(99) >= 24);
        end
    end

    initial begin : run_control
        int random_items;
        int seq_len;
        logic [1:0] mode;
        random_items = 0;

        // Directed part: empty pops, unused mode, extreme values on both stacks,
        // draining past empty, and clear followed by pops.
        add_op(sasd_pkg::MODE_POP,   1'b0, 32'h0);
        add_op(sasd_pkg::MODE_POP,   1'b1, 32'h0);
        add_op(MODE_UNUSED,          1'b0, 32'h0);
        add_op(MODE_UNUSED,          1'b1, 32'hFFFF_FFFF);
        add_op(sasd_pkg::MODE_PUSH,  1'b0, 32'h7FFF_FFFF);
        add_op(sasd_pkg::MODE_PUSH,  1'b1, 32'h8000_0000);
        add_op(sasd_pkg::MODE_PUSH,  1'b0, 32'h0000_0000);
        add_op(sasd_pkg::MODE_PUSH,  1'b1, 32'hFFFF_FFFF);
        add_op(sasd_pkg::MODE_PUSH,  1'b0, 32'hAAAA_AAAA);
        add_op(sasd_pkg::MODE_PUSH,  1'b1, 32'h5555_5555);
        add_op(MODE_UNUSED,          1'b0, 32'h1234_5678);
        for (int i = 0; i < 3; i++) begin
            add_op(sasd_pkg::MODE_POP, 1'b0, 32'hFFFF_FFFF);
            add_op(sasd_pkg::MODE_POP, 1'b1, 32'h0);
        end
        add_op(sasd_pkg::MODE_POP,   1'b0, 32'h0);
        add_op(sasd_pkg::MODE_PUSH,  1'b0, 32'h1234_5678);
        add_op(sasd_pkg::MODE_PUSH,  1'b1, 32'hDEAD_BEEF);
        add_op(sasd_pkg::MODE_CLEAR, 1'b1, 32'hFFFF_FFFF);
        add_op(sasd_pkg::MODE_POP,   1'b0, 32'h0);
        add_op(sasd_pkg::MODE_POP,   1'b1, 32'h0);
        add_op(sasd_pkg::MODE_CLEAR, 1'b0, 32'h0);

        // Random part built from fill bursts (reaching full), drain bursts
        // (reaching empty), mixed traffic, and raw noise.
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(19))
                0, 1, 2: begin
                    seq_len = $urandom_range(36, 20);
                    for (int i = 0; i < seq_len; i++)
                        add_op(sasd_pkg::MODE_PUSH, 1'($urandom_range(1)), pick_value());
                    random_items += seq_len;
                end
                3, 4, 5: begin
                    seq_len = $urandom_range(40, 10);
                    for (int i = 0; i < seq_len; i++)
                        add_op(sasd_pkg::MODE_POP, 1'($urandom_range(1)), $urandom());
                    random_items += seq_len;
                end
                6, 7: begin
                    seq_len = $urandom_range(8, 1);
                    for (int i = 0; i < seq_len; i++) begin
                        mode = 2'($urandom_range(3));
                        add_op(mode, 1'($urandom_range(1)), $urandom());
                        if (mode != MODE_UNUSED)
                            random_items++;
                    end
                end
                default: begin
                    seq_len = $urandom_range(16, 4);
                    for (int i = 0; i < seq_len; i++) begin
                        case ($urandom_range(19))
                            0:       mode = sasd_pkg::MODE_CLEAR;
                            1:       mode = MODE_UNUSED;
                            2, 3, 4, 5, 6, 7, 8, 9, 10: mode = sasd_pkg::MODE_PUSH;
                            default: mode = sasd_pkg::MODE_POP;
                        endcase
                        add_op(mode, 1'($urandom_range(1)), pick_value());
                        if (mode != MODE_UNUSED)
                            random_items++;
                    end
                end
            endcase
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Checked just after each rising edge, once the driver and monitor have settled.
        do begin
            @(posedge aclk);
            #1;
        end while (pending_ops.size() != 0 || s_tvalid || awaited_results.size() != 0);
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
